>>> sv/dlrs_pkg.sv
// ----------------------------------------------------------------------------
// dlrs_pkg: shared types and constants for the delay line ramp stepper
// Field widths, register map, operation and status codes, result beat type.
// ----------------------------------------------------------------------------
package dlrs_pkg;

    localparam int CODE_W       = 11;
    localparam int INTERVAL_W   = 20;
    localparam int MAX_CODE_DEF = 2047;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index as decoded from paddr[2]
    localparam logic REG_STEP_SIZE     = 1'b0;
    localparam logic REG_STEP_INTERVAL = 1'b1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic ST_DONE   = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef logic [CODE_W-1:0]     t_code;
    typedef logic [INTERVAL_W-1:0] t_interval;

    typedef struct packed {
        t_code delay_word;
        logic  status;
        logic  last;
    } t_result;

    // up to two result beats produced by one accepted item
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

>>> sv/dlrs_cfg.sv
// ----------------------------------------------------------------------------
// dlrs_cfg: APB configuration registers
// Holds the step stride and tick period registers; zero-wait writes and reads.
// ----------------------------------------------------------------------------
module dlrs_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dlrs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dlrs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dlrs_pkg::APB_DATA_W-1:0] prdata,
    output logic                          pready,
    output dlrs_pkg::t_code               o_step_size,
    output dlrs_pkg::t_interval           o_step_interval
);
    import dlrs_pkg::*;

    t_code     r_step_size;
    t_interval r_step_interval;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size     <= '0;
            r_step_interval <= '0;
        end else if (wr_en) begin
            if (paddr[2] == REG_STEP_SIZE) begin
                r_step_size <= pwdata[CODE_W-1:0];
            end else begin
                r_step_interval <= pwdata[INTERVAL_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_STEP_SIZE) begin
            prdata = APB_DATA_W'(r_step_size);
        end else begin
            prdata = APB_DATA_W'(r_step_interval);
        end
    end

    assign o_step_size     = r_step_size;
    assign o_step_interval = r_step_interval;

endmodule

>>> sv/dlrs_core.sv
// ----------------------------------------------------------------------------
// dlrs_core: ramp state and step logic
// Handles one accepted start or tick beat per cycle and hands its results to the queue.
// ----------------------------------------------------------------------------
module dlrs_core #(
    parameter int MAX_CODE = dlrs_pkg::MAX_CODE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_operation,
    input  dlrs_pkg::t_code     i_start_code,
    input  dlrs_pkg::t_code     i_target_code,
    input  dlrs_pkg::t_code     i_step_size,
    input  dlrs_pkg::t_interval i_step_interval,
    output dlrs_pkg::t_push     o_push
);
    import dlrs_pkg::*;

    localparam t_code MAX_C = CODE_W'(MAX_CODE);

    t_code     r_current, n_current;
    t_code     r_goal, n_goal;
    logic      r_up, n_up;
    logic      r_active, n_active;
    t_interval r_wait, n_wait;

    t_interval       wait_dec;
    logic [CODE_W:0] sum_up;
    t_code           diff_dn;
    logic            step_bad;
    logic            finish;
    t_code           next_code;
    t_push           push;

    always_comb begin
        wait_dec = (r_wait != '0) ? r_wait - 1'b1 : '0;
        sum_up   = {1'b0, r_current} + {1'b0, i_step_size};
        // clamp at zero instead of wrapping
        diff_dn  = (r_current > i_step_size) ? r_current - i_step_size : '0;
        step_bad = (i_step_size == '0) || (i_step_size > MAX_C);
        if (step_bad) begin
            finish    = 1'b1;
            next_code = r_goal;
        end else if (r_up) begin
            finish    = sum_up >= {1'b0, r_goal};
            next_code = sum_up[CODE_W-1:0];
        end else begin
            finish    = diff_dn <= r_goal;
            next_code = diff_dn;
        end
    end

    always_comb begin
        n_current = r_current;
        n_goal    = r_goal;
        n_up      = r_up;
        n_active  = r_active;
        n_wait    = r_wait;
        push      = '0;
        if (i_accept) begin
            if (i_operation == OP_START) begin
                if ((i_start_code > MAX_C) || (i_target_code > MAX_C)
                        || (i_step_size > MAX_C)) begin
                    push.count = 2'd1;
                    push.res0  = '{delay_word: '0, status: ST_REJECT, last: 1'b1};
                end else begin
                    push.res0 = '{delay_word: i_start_code, status: ST_DONE, last: 1'b0};
                    n_current = i_start_code;
                    n_goal    = i_target_code;
                    if ((i_step_size == '0) || (i_start_code == i_target_code)) begin
                        push.count = 2'd2;
                        push.res1  = '{delay_word: i_target_code, status: ST_DONE,
                                       last: 1'b1};
                        n_current  = i_target_code;
                        n_up       = 1'b0;
                        n_active   = 1'b0;
                        n_wait     = '0;
                    end else begin
                        push.count = 2'd1;
                        n_up       = i_target_code > i_start_code;
                        n_active   = 1'b1;
                        n_wait     = i_step_interval;
                    end
                end
            end else if (r_active) begin
                n_wait = wait_dec;
                if (wait_dec == '0) begin
                    push.count = 2'd1;
                    if (finish) begin
                        push.res0 = '{delay_word: r_goal, status: ST_DONE, last: 1'b1};
                        n_current = r_goal;
                        n_active  = 1'b0;
                    end else begin
                        push.res0 = '{delay_word: next_code, status: ST_DONE, last: 1'b0};
                        n_current = next_code;
                        n_wait    = i_step_interval;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current <= '0;
            r_goal    <= '0;
            r_up      <= 1'b0;
            r_active  <= 1'b0;
            r_wait    <= '0;
        end else begin
            r_current <= n_current;
            r_goal    <= n_goal;
            r_up      <= n_up;
            r_active  <= n_active;
            r_wait    <= n_wait;
        end
    end

    assign o_push = push;

    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_wait == '0))
        else $error("wait count left nonzero while idle");

    a_up_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_up) |-> (r_current < r_goal))
        else $error("rising ramp reached its goal without finishing");

    a_down_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !r_up) |-> (r_current > r_goal))
        else $error("falling ramp reached its goal without finishing");

endmodule

>>> sv/dlrs_outq.sv
// ----------------------------------------------------------------------------
// dlrs_outq: three-slot result queue
// Takes up to two result beats per cycle and presents them in order.
// ----------------------------------------------------------------------------
module dlrs_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dlrs_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output dlrs_pkg::t_result o_result
);
    import dlrs_pkg::*;

    localparam int DEPTH = 3;

    t_result    r_slot [DEPTH];
    t_result    n_slot [DEPTH];
    logic [1:0] r_count, n_count;
    logic [1:0] cnt_after_pop;
    logic       pop;

    assign pop           = i_ready && (r_count != 2'd0);
    assign cnt_after_pop = r_count - {1'b0, pop};

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            // shift down on pop, then drop new beats behind what is left
            if (pop && (k < DEPTH - 1)) begin
                n_slot[k] = r_slot[k+1];
            end else begin
                n_slot[k] = r_slot[k];
            end
            if ((i_push.count != 2'd0) && (cnt_after_pop == 2'(k))) begin
                n_slot[k] = i_push.res0;
            end
            if ((i_push.count == 2'd2) && ((cnt_after_pop + 2'd1) == 2'(k))) begin
                n_slot[k] = i_push.res1;
            end
        end
        n_count = cnt_after_pop + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_room   = r_count <= 2'd1;
    assign o_valid  = r_count != 2'd0;
    assign o_result = r_slot[0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> o_room)
        else $error("result pushed without room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && (i_push.count == 2'd0)) |=> (r_count == $past(r_count) - 2'd1))
        else $error("pop did not drain one beat");

endmodule

>>> sv/delay_line_ramp_stepper_top.sv
// ----------------------------------------------------------------------------
// delay_line_ramp_stepper_top: setpoint ramp generator for a delay line
// Steps a delay code from a start value to a target, one write per interval.
//
//   channel  direction  handshake            payload
//   in       sink       i_valid / o_ready    i_operation, i_start_code,
//                                            i_target_code
//   out      source     o_valid / i_ready    o_delay_word, o_status, o_last
//   cfg      APB        psel/penable/pready  step stride @0x0, tick period @0x4
//
// One input beat per cycle while o_ready is high; its results enter the output
// queue at the edge that accepts it, so an empty queue offers the first result
// beat the next cycle. A start that finishes at once yields two result beats,
// others at most one. o_ready is high while the three-slot queue has room for
// two beats, so a stalled sink holds input back once two result beats wait.
// Reset is synchronous; it clears the ramp, both registers and the queue.
// ----------------------------------------------------------------------------
module delay_line_ramp_stepper_top #(
    parameter int MAX_CODE = dlrs_pkg::MAX_CODE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dlrs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [dlrs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [dlrs_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_operation,
    input  dlrs_pkg::t_code                 i_start_code,
    input  dlrs_pkg::t_code                 i_target_code,
    output logic                            o_valid,
    input  logic                            i_ready,
    output dlrs_pkg::t_code                 o_delay_word,
    output logic                            o_status,
    output logic                            o_last
);
    import dlrs_pkg::*;

    t_code     cfg_stride;
    t_interval cfg_period;
    t_push     push;
    t_result   result;
    logic      room;

    assign o_ready = room;

    dlrs_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_step_size     (cfg_stride),
        .o_step_interval (cfg_period)
    );

    dlrs_core #(
        .MAX_CODE (MAX_CODE)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (i_valid & room),
        .i_operation     (i_operation),
        .i_start_code    (i_start_code),
        .i_target_code   (i_target_code),
        .i_step_size     (cfg_stride),
        .i_step_interval (cfg_period),
        .o_push          (push)
    );

    dlrs_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room   (room),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_delay_word = result.delay_word;
    assign o_status     = result.status;
    assign o_last       = result.last;

endmodule
